[rtl/assert_macros.svh]
// Assertion macros for the RTL of the byte pattern scanner; included by wbps_queue.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHECK_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CHECK_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/wbps_pkg.sv]
// Package of the wildcard byte pattern scanner: constants, register codes, result type.
// No dependencies; imported by every module of the block.
`default_nettype none

package wbps_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 5;
   localparam int PAT_BYTES = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_OFF_W = 32;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;

   localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RSP_OFF_W-1:0] match_offset;
      logic                 match_found;
      logic                 end_of_stream;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/wbps_front.sv]
// Front of the scanner: accepts bytes, keeps window and position, compares the pattern.
// Depends on wbps_pkg; feeds wbps_queue with one record per reported byte.
`default_nettype none

module wbps_front
   import wbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [BYTE_W-1:0]     data_byte,
   input  wire logic                  last_byte,
   input  wire logic [LEN_W-1:0]      pattern_length,
   input  wire logic [2*CSR_W-1:0]    pattern_bytes,
   output      logic                  stage_busy,
   output      logic                  push_valid,
   output      rsp_item_type          push_item
);

   logic [BYTE_W-1:0]      win_ff     [PATTERN_MAX];
   logic [BYTE_W-1:0]      win_in     [PATTERN_MAX];
   logic [BYTE_W-1:0]      snap_win_ff[PATTERN_MAX];
   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] pos_in;
   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic                   s1_elig_ff;
   logic                   elig;
   logic [OFFSET_BITS-1:0] s1_off_ff;
   logic [OFFSET_BITS-1:0] off_in;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       len_m1;
   logic [BYTE_W-1:0]      pat_byte   [PAT_BYTES];
   logic [PATTERN_MAX-1:0] lane_ok;
   logic                   found;
   logic [OFFSET_BITS+RSP_OFF_W-1:0] off_ext;

   // Clamp the length to the window depth.
   always_comb begin
      if (pattern_length > LEN_W'(PATTERN_MAX)) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = pattern_length;
      end
      len_m1 = len_eff - LEN_W'(1);
   end

   always_comb begin
      for (int i = 0; i < PAT_BYTES; i++) begin
         pat_byte[i] = pattern_bytes[i*BYTE_W +: BYTE_W];
      end
   end

   // Shift the new byte into the window; entry 0 is the newest.
   always_comb begin
      win_in[0] = data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   // Match is possible once enough bytes arrived, the length is nonzero and the position is not saturated.
   always_comb begin
      elig   = (len_eff != '0) && (pos_ff != '1) &&
               (pos_ff >= {{(OFFSET_BITS-LEN_W){1'b0}}, len_m1});
      off_in = pos_ff - {{(OFFSET_BITS-LEN_W){1'b0}}, len_m1};
      if (last_byte) begin
         pos_in = '0;
      end else if (pos_ff == '1) begin
         pos_in = pos_ff;
      end else begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            pos_ff <= pos_in;
            for (int k = 0; k < PATTERN_MAX; k++) begin
               win_ff[k] <= last_byte ? '0 : win_in[k];
            end
         end
      end
   end

   // Snapshot of the window for the compare stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= last_byte;
         s1_elig_ff <= elig;
         s1_off_ff  <= off_in;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            snap_win_ff[k] <= win_in[k];
         end
      end
   end

   // Lane k holds the byte k steps old and meets pattern byte len-1-k.
   always_comb begin
      logic [LEN_W-1:0] j;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         j = len_m1 - LEN_W'(k);
         lane_ok[k] = (LEN_W'(k) >= len_eff) ||
                      (pat_byte[j[3:0]] == WILDCARD_BYTE) ||
                      (snap_win_ff[k] == pat_byte[j[3:0]]);
      end
   end

   assign found   = s1_elig_ff && (&lane_ok);
   assign off_ext = {{RSP_OFF_W{1'b0}}, s1_off_ff};

   assign stage_busy               = s1_valid_ff;
   assign push_valid               = s1_valid_ff && (found || s1_last_ff);
   assign push_item.match_offset   = found ? off_ext[RSP_OFF_W-1:0] : '0;
   assign push_item.match_found    = found;
   assign push_item.end_of_stream  = s1_last_ff;

endmodule

`default_nettype wire

[rtl/wbps_queue.sv]
// Back of the scanner: short result queue between compare stage and result port.
// Depends on wbps_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wbps_queue
   import wbps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire rsp_item_type       push_item,
   input  wire logic               pop_accept,
   output      rsp_item_type       head_item,
   output      logic               empty,
   output      logic [QCNT_W-1:0]  count
);

   rsp_item_type      mem_ff[QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop_accept) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_valid && pop_accept) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_accept) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

   `CHECK_NEVER(a_no_overflow, clock, reset, push_valid && (count_ff == QCNT_W'(QDEPTH)) && !pop_accept, "result queue overflow")
   `CHECK_HOLDS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QDEPTH), "result queue count out of range")
   `CHECK_HOLDS(a_push_grows, clock, reset, (push_valid && !pop_accept) |=> (count_ff == $past(count_ff) + QCNT_W'(1)), "push not counted")

endmodule

`default_nettype wire

[rtl/wildcard_byte_pattern_scanner_top.sv]
// Top level of the wildcard byte pattern scanner: CSRs, front compare, result queue.
// Depends on wbps_pkg, wbps_front and wbps_queue.
//
//   channel   ports                                  handshake
//   --------  -------------------------------------  ------------------------------
//   input     req_data_byte, req_last_byte            push & !full
//   result    rsp_match_offset/found, end_of_stream   pop & !empty
//   config    csr_index, csr_wdata                    csr_wr_en (no wait)
//
// One byte per cycle sustained while full stays low; the window shift and compare
// snapshot share the accepting edge, and the queue write for a reported byte
// follows from the compare stage.
// The four-entry result queue absorbs stalls; full rises once the queue plus the
// compare stage could not take another result.
// Reset (synchronous, active high) clears the CSRs, window, position and queue.
`default_nettype none

module wildcard_byte_pattern_scanner_top
   import wbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input transaction
   input  wire logic                  push,
   output      logic                  full,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_last_byte,
   // result transaction
   output      logic                  empty,
   input  wire logic                  pop,
   output      logic [RSP_OFF_W-1:0]  rsp_match_offset,
   output      logic                  rsp_match_found,
   output      logic                  rsp_end_of_stream,
   // register writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   logic [LEN_W-1:0]   pat_len_ff;
   logic [CSR_W-1:0]   pat_low_ff;
   logic [CSR_W-1:0]   pat_high_ff;
   logic               accept;
   logic               pop_accept;
   logic               stage_busy;
   logic               push_valid;
   rsp_item_type       push_item;
   rsp_item_type       head_item;
   logic [QCNT_W-1:0]  q_count;
   logic [QCNT_W:0]    q_need;

   // Register writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: pat_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_LOW:    pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_ff <= csr_wdata;
            default:            pat_len_ff  <= pat_len_ff;
         endcase
      end
   end

   // Hold off the input when the queue cannot take the result of the byte in
   // the compare stage plus one more.
   assign q_need     = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(stage_busy);
   assign full       = (q_need >= (QCNT_W+1)'(QDEPTH));
   assign accept     = push && !full;
   assign pop_accept = pop && !empty;

   wbps_front #(
      .PATTERN_MAX (PATTERN_MAX),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .pattern_length (pat_len_ff),
      .pattern_bytes  ({pat_high_ff, pat_low_ff}),
      .stage_busy     (stage_busy),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   wbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_accept (pop_accept),
      .head_item  (head_item),
      .empty      (empty),
      .count      (q_count)
   );

   assign rsp_match_offset  = head_item.match_offset;
   assign rsp_match_found   = head_item.match_found;
   assign rsp_end_of_stream = head_item.end_of_stream;

endmodule

`default_nettype wire
